// File: src/grce_pkg.sv
// Shared constants, types and functions for the grid ray cast engine.
// No dependencies; every other file of the block but grce_ram refers to this package.
package grce_pkg;

    localparam int MAP_SIDE     = 16;
    localparam int MAX_STEPS    = 12;
    localparam int TRIG_ENTRIES = 1024;

    // field widths
    localparam int COL_W      = 10;
    localparam int ANG_W      = 16;
    localparam int POS_IN_W   = 20;
    localparam int CELL_IN_W  = 4;
    localparam int HIT_W      = 22;
    localparam int CS_W       = 8;
    localparam int SPREAD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // internal widths
    localparam int OFS_W  = CS_W + 8;          // cell side in Q8
    localparam int DIR_W  = 17;                // direction, major axis = 65536
    localparam int TRIG_W = 15;                // 0..16384
    localparam int PROD_W = OFS_W + DIR_W;

    localparam int POS_W_MIN = $clog2((1 << POS_IN_W) + (MAX_STEPS + 1) * (1 << OFS_W)) + 1;
    localparam int POS_W     = (POS_W_MIN > HIT_W) ? POS_W_MIN : HIT_W + 1;
    localparam int CELL_W    = POS_W - 7;      // cell side is at least 256
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam int MAP_W   = $clog2(MAP_SIDE);
    localparam int CELLS   = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COORD_W = ((MAP_W > CELL_IN_W) ? MAP_W : CELL_IN_W) + 1;

    localparam int TRIG_BITS = $clog2(TRIG_ENTRIES);
    localparam int QTR_BITS  = TRIG_BITS - 2;
    localparam int QTR_N     = TRIG_ENTRIES / 4;
    localparam int LUT_N     = QTR_N + 1;
    localparam int LUT_W     = QTR_BITS + 1;

    // shared divider
    localparam int DIV_NW    = PROD_W;
    localparam int DIV_DW    = DIR_W;
    localparam int DIV_QW    = 20;
    localparam int DIV_STEP  = 4;
    localparam int DIV_CYC   = DIV_QW / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAY_SPREAD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COLUMN = 2'd2;

    localparam logic [CS_W-1:0]     CELL_SIZE_RST = 8'd64;
    localparam logic [SPREAD_W-1:0] SPREAD_RST    = 8'd21;
    localparam logic [COL_W-1:0]    CENTER_RST    = 10'd256;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam int          TRIG_ONE = 16384;

    typedef logic [TRIG_W-1:0] t_sin_lut [LUT_N];

    // quarter-wave sine, Q14, integer Q30 Taylor series
    function automatic t_sin_lut build_sin_lut();
        t_sin_lut    lut;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] v;
        for (int j = 0; j < LUT_N; j++) begin
            x = (PI_Q30 * 64'(4 * j)) / 64'(2 * TRIG_ENTRIES);
            s = x;
            t = x;
            for (int i = 1; i <= 5; i++) begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / 64'((2 * i) * (2 * i + 1));
                if ((i % 2) == 1) begin
                    s = (s >= t) ? s - t : 64'd0;
                end else begin
                    s = s + t;
                end
            end
            v = (s + 64'd32768) >> 16;
            if (v > 64'(TRIG_ONE)) begin
                v = 64'(TRIG_ONE);
            end
            lut[j] = v[TRIG_W-1:0];
        end
        return lut;
    endfunction

    localparam t_sin_lut SIN_LUT = build_sin_lut();

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        return ADDR_W'(y * MAP_SIDE + x);
    endfunction

endpackage

// File: src/grce_if.sv
// Channel interfaces of the grid ray cast engine: request, result, config.
// Depends on grce_pkg for field widths.
interface grce_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [grce_pkg::CELL_IN_W-1:0]        cell_x;
    logic [grce_pkg::CELL_IN_W-1:0]        cell_y;
    logic                                  cell_wall;
    logic [grce_pkg::POS_IN_W-1:0]         pos_x;
    logic [grce_pkg::POS_IN_W-1:0]         pos_y;
    logic [grce_pkg::ANG_W-1:0]            player_angle;
    logic [grce_pkg::COL_W-1:0]            column;

    modport source (output valid, req_type, cell_x, cell_y, cell_wall, pos_x, pos_y,
                    player_angle, column, input ready);
    modport sink   (input valid, req_type, cell_x, cell_y, cell_wall, pos_x, pos_y,
                    player_angle, column, output ready);
endinterface

interface grce_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [grce_pkg::COL_W-1:0]            column_out;
    logic signed [grce_pkg::HIT_W-1:0]     hit_x;
    logic signed [grce_pkg::HIT_W-1:0]     hit_y;
    logic                                  side;
    logic [grce_pkg::ANG_W-1:0]            ray_angle;
    logic                                  wall_hit;
    logic                                  left_map;

    modport source (output valid, column_out, hit_x, hit_y, side, ray_angle, wall_hit,
                    left_map, input ready);
    modport sink   (input valid, column_out, hit_x, hit_y, side, ray_angle, wall_hit,
                    left_map, output ready);
endinterface

interface grce_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [grce_pkg::CFG_IDX_W-1:0]        index;
    logic [grce_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/grce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/grce_div.sv
// Shared restoring divider, DIV_STEP quotient bits per cycle.
// Depends on grce_pkg. Needs num < den * 2**DIV_QW.
module grce_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [grce_pkg::DIV_NW-1:0]   i_num,
    input  logic [grce_pkg::DIV_DW-1:0]   i_den,
    output logic                          o_done,
    output logic [grce_pkg::DIV_QW-1:0]   o_quo,
    output logic [grce_pkg::DIV_DW-1:0]   o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [grce_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [grce_pkg::DIV_DW-1:0]    r_rem;
    logic [grce_pkg::DIV_QW-1:0]    r_num;   // dividend bits out, quotient bits in
    logic [grce_pkg::DIV_DW-1:0]    r_den;
    logic [grce_pkg::DIV_DW-1:0]    n_rem;
    logic [grce_pkg::DIV_QW-1:0]    n_num;

    always_comb begin
        logic [grce_pkg::DIV_DW:0]   rem_t;
        logic [grce_pkg::DIV_QW-1:0] q_t;
        rem_t = {1'b0, r_rem};
        q_t   = r_num;
        for (int b = 0; b < grce_pkg::DIV_STEP; b++) begin
            rem_t = {rem_t[grce_pkg::DIV_DW-1:0], q_t[grce_pkg::DIV_QW-1]};
            q_t   = {q_t[grce_pkg::DIV_QW-2:0], 1'b0};
            if (rem_t >= {1'b0, r_den}) begin
                rem_t = rem_t - {1'b0, r_den};
                q_t[0] = 1'b1;
            end
        end
        n_rem = rem_t[grce_pkg::DIV_DW-1:0];
        n_num = q_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == grce_pkg::DIV_CNT_W'(grce_pkg::DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= grce_pkg::DIV_DW'(i_num[grce_pkg::DIV_NW-1:grce_pkg::DIV_QW]);
            r_num <= i_num[grce_pkg::DIV_QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

// File: src/grid_ray_cast_engine.sv
// Grid ray cast engine: one result beat per cast beat, none per map-write beat.
// Map write: written to the wall RAM in the cycle it is taken. A cast walks N edge
// crossings (N = 1..MAX_STEPS) before its result register is loaded, and uses the
// shared divider for four divisions at setup and one per crossing.
// Reset: synchronous, active low; config returns to 64/21/256 and a clearing pass
// over all MAP_SIDE*MAP_SIDE cells (256) empties the wall RAM before requests are taken.
module grid_ray_cast_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    grce_req_if.sink   i_req,
    grce_rsp_if.source o_rsp,
    grce_cfg_if.sink   i_cfg
);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ANG  = 4'd2;
    localparam logic [3:0] S_TRIG = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_DIVW = 4'd5;
    localparam logic [3:0] S_ADJ  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_MVW  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_RD   = 4'd11;
    localparam logic [3:0] S_CHK  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    // setup divisions, in issue order
    localparam logic [1:0] DSEL_CELL_X = 2'd0;
    localparam logic [1:0] DSEL_CELL_Y = 2'd1;
    localparam logic [1:0] DSEL_DIR_X  = 2'd2;
    localparam logic [1:0] DSEL_DIR_Y  = 2'd3;

    localparam int PW = grce_pkg::POS_W;
    localparam int CW = grce_pkg::CELL_W;
    localparam int OW = grce_pkg::OFS_W;

    localparam logic signed [PW-1:0] HIT_MAXP = PW'(2 ** (grce_pkg::HIT_W - 1) - 1);
    localparam logic signed [PW-1:0] HIT_MINP = -PW'(2 ** (grce_pkg::HIT_W - 1));

    function automatic logic signed [grce_pkg::HIT_W-1:0] sat_hit(
        input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        c = v;
        if (v > HIT_MAXP) begin
            c = HIT_MAXP;
        end else if (v < HIT_MINP) begin
            c = HIT_MINP;
        end
        return c[grce_pkg::HIT_W-1:0];
    endfunction

    // control
    logic [3:0]                    r_state;
    logic [grce_pkg::ADDR_W-1:0]   r_clr;
    logic [1:0]                    r_div_sel;
    logic [grce_pkg::STEP_W-1:0]   r_step;
    logic                          r_ovalid;

    // config
    logic [grce_pkg::CS_W-1:0]     r_cell_size;
    logic [grce_pkg::SPREAD_W-1:0] r_ray_spread;
    logic [grce_pkg::COL_W-1:0]    r_center;

    // ray datapath
    logic [grce_pkg::COL_W-1:0]    r_col;
    logic [grce_pkg::ANG_W-1:0]    r_ang;
    logic [grce_pkg::TRIG_W-1:0]   r_ac, r_as;
    logic                          r_xpos, r_ypos;
    logic [grce_pkg::DIR_W-1:0]    r_dxm, r_dym;
    logic signed [PW-1:0]          r_px, r_py;
    logic signed [CW-1:0]          r_cx, r_cy;
    logic [OW-1:0]                 r_ox, r_oy;      // offset inside the cell
    logic [OW-1:0]                 r_atx, r_aty;    // distance to next edge
    logic [grce_pkg::PROD_W-1:0]   r_pa, r_pb;
    logic                          r_xfirst;
    logic [OW-1:0]                 r_mv;
    logic                          r_inb;
    logic                          r_side, r_wall, r_left;

    // result register
    logic [grce_pkg::COL_W-1:0]        r_o_col;
    logic signed [grce_pkg::HIT_W-1:0] r_o_hx, r_o_hy;
    logic                              r_o_side;
    logic [grce_pkg::ANG_W-1:0]        r_o_ang;
    logic                              r_o_wall, r_o_left;

    // next values of the walk state
    logic signed [PW-1:0] n_px, n_py;
    logic signed [CW-1:0] n_cx, n_cy;
    logic [OW-1:0]        n_ox, n_oy, n_atx, n_aty;

    logic                 in_fire, cfg_fire, out_load, w_wr;
    logic [OW-1:0]        w_cq;
    logic [grce_pkg::ANG_W-1:0] w_diff, w_turn;

    // divider port
    logic                        div_start, div_done;
    logic [grce_pkg::DIV_NW-1:0] div_num;
    logic [grce_pkg::DIV_DW-1:0] div_den;
    logic [grce_pkg::DIV_QW-1:0] div_quo;
    logic [grce_pkg::DIV_DW-1:0] div_rem;

    // wall RAM port
    logic                        ram_we, ram_wdata, ram_rdata;
    logic [grce_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;

    // trig lookup
    logic [grce_pkg::TRIG_BITS-1:0] w_k;
    logic [1:0]                     w_qs, w_qc;
    logic [grce_pkg::LUT_W-1:0]     w_js, w_jc, w_jr;
    logic [grce_pkg::TRIG_W-1:0]    w_sv, w_cv, w_major;

    logic                           w_xlt, w_den_zero, w_inb;
    logic [OW:0]                    w_sumx, w_sumy;
    logic signed [PW-1:0]           w_atx_s, w_aty_s, w_mv_s;

    assign in_fire  = i_req.valid && i_req.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // cell side in Q8; a zero size counts as one
    assign w_cq = {((r_cell_size == '0) ? grce_pkg::CS_W'(1) : r_cell_size), 8'd0};

    // ray angle: player angle + (column - center) * spread, mod one turn
    assign w_diff = grce_pkg::ANG_W'(r_col) - grce_pkg::ANG_W'(r_center);
    assign w_turn = w_diff * {{(grce_pkg::ANG_W - grce_pkg::SPREAD_W){1'b0}}, r_ray_spread};

    // quadrant folding of the quarter-wave table; cos is sin a quarter turn on
    assign w_k  = r_ang[grce_pkg::ANG_W-1 -: grce_pkg::TRIG_BITS];
    assign w_qs = w_k[grce_pkg::TRIG_BITS-1 -: 2];
    assign w_qc = w_qs + 2'd1;
    assign w_jr = {1'b0, w_k[grce_pkg::QTR_BITS-1:0]};
    assign w_js = w_qs[0] ? grce_pkg::LUT_W'(grce_pkg::QTR_N) - w_jr : w_jr;
    assign w_jc = w_qc[0] ? grce_pkg::LUT_W'(grce_pkg::QTR_N) - w_jr : w_jr;
    assign w_sv = grce_pkg::SIN_LUT[w_js];
    assign w_cv = grce_pkg::SIN_LUT[w_jc];

    assign w_major = (r_ac > r_as) ? r_ac :
                     ((r_as == '0) ? grce_pkg::TRIG_W'(1) : r_as);

    // nearer edge first; a tie goes to the y edge
    assign w_xlt      = r_pa < r_pb;
    assign w_den_zero = r_xfirst ? (r_dxm == '0) : (r_dym == '0);

    assign w_atx_s = $signed({{(PW - OW){1'b0}}, r_atx});
    assign w_aty_s = $signed({{(PW - OW){1'b0}}, r_aty});
    assign w_mv_s  = $signed({{(PW - OW){1'b0}}, r_mv});
    assign w_sumx  = {1'b0, r_ox} + {1'b0, r_mv};
    assign w_sumy  = {1'b0, r_oy} + {1'b0, r_mv};

    assign w_inb = (r_cx >= 0) && (r_cx < CW'(grce_pkg::MAP_SIDE)) &&
                   (r_cy >= 0) && (r_cy < CW'(grce_pkg::MAP_SIDE));

    // walk state: edge pre-adjust in S_ADJ, crossing in S_UPD
    always_comb begin
        n_px  = r_px;
        n_py  = r_py;
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_ox  = r_ox;
        n_oy  = r_oy;
        n_atx = r_atx;
        n_aty = r_aty;
        if (r_state == S_ADJ) begin
            // non-positive axis sitting on an edge drops one LSB into the cell below
            if (!r_xpos && r_ox == '0) begin
                n_px = r_px - PW'(1);
                n_cx = r_cx - CW'(1);
                n_ox = w_cq - OW'(1);
            end
            if (!r_ypos && r_oy == '0) begin
                n_py = r_py - PW'(1);
                n_cy = r_cy - CW'(1);
                n_oy = w_cq - OW'(1);
            end
            n_atx = r_xpos ? w_cq - r_ox : n_ox;
            n_aty = r_ypos ? w_cq - r_oy : n_oy;
        end else if (r_state == S_UPD) begin
            if (r_xfirst) begin
                if (r_xpos) begin
                    n_px = r_px + w_atx_s;
                    n_cx = r_cx + CW'(1);
                    n_ox = '0;
                end else begin
                    n_px = r_px - w_atx_s - PW'(1);
                    n_cx = r_cx - CW'(1);
                    n_ox = w_cq - OW'(1);
                end
                if (r_ypos) begin
                    n_py = r_py + w_mv_s;
                    if (w_sumy >= {1'b0, w_cq}) begin
                        n_cy = r_cy + CW'(1);
                        n_oy = OW'(w_sumy - {1'b0, w_cq});
                    end else begin
                        n_oy = w_sumy[OW-1:0];
                    end
                end else begin
                    n_py = r_py - w_mv_s;
                    n_oy = r_oy - r_mv;
                end
            end else begin
                if (r_ypos) begin
                    n_py = r_py + w_aty_s;
                    n_cy = r_cy + CW'(1);
                    n_oy = '0;
                end else begin
                    n_py = r_py - w_aty_s - PW'(1);
                    n_cy = r_cy - CW'(1);
                    n_oy = w_cq - OW'(1);
                end
                if (r_xpos) begin
                    n_px = r_px + w_mv_s;
                    // y crossing can carry x exactly onto the next edge
                    if (w_sumx >= {1'b0, w_cq}) begin
                        n_cx = r_cx + CW'(1);
                        n_ox = OW'(w_sumx - {1'b0, w_cq});
                    end else begin
                        n_ox = w_sumx[OW-1:0];
                    end
                end else begin
                    n_px = r_px - w_mv_s;
                    n_ox = r_ox - r_mv;
                end
            end
        end
    end

    // divider operand select
    always_comb begin
        div_start = (r_state == S_DIV) || (r_state == S_CMP);
        div_num   = w_xlt ? r_pa : r_pb;
        div_den   = w_xlt ? r_dxm : r_dym;
        if (r_state == S_DIV) begin
            case (r_div_sel)
                DSEL_CELL_X: begin
                    div_num = grce_pkg::DIV_NW'(r_px[grce_pkg::POS_IN_W-1:0]);
                    div_den = grce_pkg::DIV_DW'(w_cq);
                end
                DSEL_CELL_Y: begin
                    div_num = grce_pkg::DIV_NW'(r_py[grce_pkg::POS_IN_W-1:0]);
                    div_den = grce_pkg::DIV_DW'(w_cq);
                end
                DSEL_DIR_X: begin
                    div_num = grce_pkg::DIV_NW'({r_ac, 16'd0});
                    div_den = grce_pkg::DIV_DW'(w_major);
                end
                default: begin
                    div_num = grce_pkg::DIV_NW'({r_as, 16'd0});
                    div_den = grce_pkg::DIV_DW'(w_major);
                end
            endcase
        end
    end

    // wall RAM: clearing pass, map writes from the request channel, reads in S_RD
    assign w_wr = in_fire && (i_req.req_type == grce_pkg::REQ_WRITE) &&
                  (grce_pkg::COORD_W'(i_req.cell_x) < grce_pkg::COORD_W'(grce_pkg::MAP_SIDE)) &&
                  (grce_pkg::COORD_W'(i_req.cell_y) < grce_pkg::COORD_W'(grce_pkg::MAP_SIDE));
    assign ram_we    = (r_state == S_CLR) || w_wr;
    assign ram_waddr = (r_state == S_CLR) ? r_clr :
                       grce_pkg::cell_addr(grce_pkg::COORD_W'(i_req.cell_x),
                                           grce_pkg::COORD_W'(i_req.cell_y));
    assign ram_wdata = (r_state == S_CLR) ? 1'b0 : i_req.cell_wall;
    assign ram_raddr = grce_pkg::cell_addr(r_cx[grce_pkg::COORD_W-1:0],
                                           r_cy[grce_pkg::COORD_W-1:0]);

    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_rsp.ready);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_div_sel    <= DSEL_CELL_X;
            r_step       <= '0;
            r_ovalid     <= 1'b0;
            r_cell_size  <= grce_pkg::CELL_SIZE_RST;
            r_ray_spread <= grce_pkg::SPREAD_RST;
            r_center     <= grce_pkg::CENTER_RST;
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg.index)
                    grce_pkg::CFG_CELL_SIZE:     r_cell_size  <= i_cfg.data[grce_pkg::CS_W-1:0];
                    grce_pkg::CFG_RAY_SPREAD:    r_ray_spread <= i_cfg.data[grce_pkg::SPREAD_W-1:0];
                    grce_pkg::CFG_CENTER_COLUMN: r_center     <= i_cfg.data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == grce_pkg::ADDR_W'(grce_pkg::CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire && i_req.req_type == grce_pkg::REQ_CAST) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG:  r_state <= S_TRIG;
                S_TRIG: begin
                    r_div_sel <= DSEL_CELL_X;
                    r_state   <= S_DIV;
                end
                S_DIV:  r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        if (r_div_sel == DSEL_DIR_Y) begin
                            r_step  <= '0;
                            r_state <= S_ADJ;
                        end else begin
                            r_div_sel <= r_div_sel + 2'd1;
                            r_state   <= S_DIV;
                        end
                    end
                end
                S_ADJ:  r_state <= S_MUL;
                S_MUL:  r_state <= S_CMP;
                S_CMP:  r_state <= S_MVW;
                S_MVW: begin
                    if (div_done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD:  r_state <= S_RD;
                S_RD:   r_state <= S_CHK;
                S_CHK: begin
                    r_step <= r_step + 1'b1;
                    if ((r_inb && ram_rdata) ||
                        r_step == grce_pkg::STEP_W'(grce_pkg::MAX_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ADJ;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_col  <= i_req.column;
            r_ang  <= i_req.player_angle;
            r_px   <= $signed({{(PW - grce_pkg::POS_IN_W){1'b0}}, i_req.pos_x});
            r_py   <= $signed({{(PW - grce_pkg::POS_IN_W){1'b0}}, i_req.pos_y});
            r_wall <= 1'b0;
            r_left <= 1'b0;
            r_side <= 1'b0;
        end
        if (r_state == S_ANG) begin
            r_ang <= r_ang + w_turn;
        end
        if (r_state == S_TRIG) begin
            r_as   <= w_sv;
            r_ac   <= w_cv;
            r_ypos <= !w_qs[1] && (w_sv != '0);
            r_xpos <= !w_qc[1] && (w_cv != '0);
        end
        if (r_state == S_DIVW && div_done) begin
            case (r_div_sel)
                DSEL_CELL_X: begin
                    r_cx <= CW'(div_quo);
                    r_ox <= div_rem[OW-1:0];
                end
                DSEL_CELL_Y: begin
                    r_cy <= CW'(div_quo);
                    r_oy <= div_rem[OW-1:0];
                end
                DSEL_DIR_X: r_dxm <= div_quo[grce_pkg::DIR_W-1:0];
                default:    r_dym <= div_quo[grce_pkg::DIR_W-1:0];
            endcase
        end
        if (r_state == S_ADJ || r_state == S_UPD) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_atx <= n_atx;
            r_aty <= n_aty;
        end
        if (r_state == S_UPD) begin
            r_side <= !r_xfirst;
        end
        if (r_state == S_MUL) begin
            r_pa <= {{(grce_pkg::PROD_W - OW){1'b0}}, r_atx} *
                    {{(grce_pkg::PROD_W - grce_pkg::DIR_W){1'b0}}, r_dym};
            r_pb <= {{(grce_pkg::PROD_W - OW){1'b0}}, r_aty} *
                    {{(grce_pkg::PROD_W - grce_pkg::DIR_W){1'b0}}, r_dxm};
        end
        if (r_state == S_CMP) begin
            r_xfirst <= w_xlt;
        end
        if (r_state == S_MVW && div_done) begin
            r_mv <= w_den_zero ? '0 : div_quo[OW-1:0];
        end
        if (r_state == S_RD) begin
            r_inb <= w_inb;
        end
        if (r_state == S_CHK) begin
            if (!r_inb) begin
                r_left <= 1'b1;
            end
            if (r_inb && ram_rdata) begin
                r_wall <= 1'b1;
            end
        end
        if (out_load) begin
            r_o_col  <= r_col;
            r_o_hx   <= sat_hit(r_px);
            r_o_hy   <= sat_hit(r_py);
            r_o_side <= r_side;
            r_o_ang  <= r_ang;
            r_o_wall <= r_wall;
            r_o_left <= r_left;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.column_out = r_o_col;
    assign o_rsp.hit_x      = r_o_hx;
    assign o_rsp.hit_y      = r_o_hy;
    assign o_rsp.side       = r_o_side;
    assign o_rsp.ray_angle  = r_o_ang;
    assign o_rsp.wall_hit   = r_o_wall;
    assign o_rsp.left_map   = r_o_left;

    grce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    grce_ram #(
        .WIDTH (1),
        .DEPTH (grce_pkg::CELLS)
    ) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // offsets stay inside the cell once the walk is set up
    a_ofs_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_ox < w_cq && r_oy < w_cq))
        else $error("cell offset out of range");

    // walk never runs past the step limit
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_step < grce_pkg::STEP_W'(grce_pkg::MAX_STEPS)))
        else $error("step count past limit");

    // divider only finishes while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVW || r_state == S_MVW))
        else $error("divider result with nobody waiting");

    // a map write beat leaves the sequencer idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.req_type == grce_pkg::REQ_WRITE) |=> (r_state == S_IDLE))
        else $error("map write started a cast");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for grid_ray_cast_engine: map writes, ray casts, config writes.
// Depends on grce_pkg and the grce_*_if channel interfaces; holds its own ray predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import grce_pkg::*;

    typedef struct {
        logic                 req_type;
        logic [CELL_IN_W-1:0] cell_x;
        logic [CELL_IN_W-1:0] cell_y;
        logic                 cell_wall;
        logic [POS_IN_W-1:0]  pos_x;
        logic [POS_IN_W-1:0]  pos_y;
        logic [ANG_W-1:0]     player_angle;
        logic [COL_W-1:0]     column;
    } req_t;

    typedef struct {
        logic [COL_W-1:0]        column_out;
        logic signed [HIT_W-1:0] hit_x;
        logic signed [HIT_W-1:0] hit_y;
        logic                    side;
        logic [ANG_W-1:0]        ray_angle;
        logic                    wall_hit;
        logic                    left_map;
    } rsp_t;

    // Ray predictor plus the queue of casts still waiting for their result beat.
    class ray_scoreboard;
        bit           walls [MAP_SIDE*MAP_SIDE];
        bit [7:0]     cell_size;
        bit [7:0]     spread;
        bit [9:0]     center;
        rsp_t         pending_hits [$];
        int           errors;

        function new();
            foreach (walls[i]) walls[i] = 0;
            cell_size = CELL_SIZE_RST;
            spread    = SPREAD_RST;
            center    = CENTER_RST;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CELL_SIZE:     cell_size = val[7:0];
                CFG_RAY_SPREAD:    spread    = val[7:0];
                CFG_CENTER_COLUMN: center    = val;
                default: ;
            endcase
        endfunction

        // quarter-unit phase, Q14 result
        function int sine_q14(longint unsigned p);
            longint unsigned n, q, r, x, s, t, v;
            n = TRIG_ENTRIES;
            p = p % (4 * n);
            q = p / n;
            r = p % n;
            if (q[0]) r = n - r;
            x = (64'd3373259426 * r) / (2 * n);
            s = x;
            t = x;
            for (int i = 1; i <= 5; i++) begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / longint'((2 * i) * (2 * i + 1));
                if (i % 2 == 1) s = (s >= t) ? s - t : 0;
                else s = s + t;
            end
            v = (s + 32768) >> 16;
            if (v > 16384) v = 16384;
            return (q >= 2) ? -int'(v) : int'(v);
        endfunction

        function longint fmod(longint a, longint b);
            longint r;
            r = a % b;
            if (r < 0) r += b;
            return r;
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function logic signed [HIT_W-1:0] clip(longint v);
            if (v > 2097151) v = 2097151;
            if (v < -2097152) v = -2097152;
            return v[HIT_W-1:0];
        endfunction

        function void note_request(req_t r);
            rsp_t     e;
            bit [31:0] a32;
            int       c, s, ac, as, major;
            longint   dxm, dym, cq, px, py, tx, ty, atx, aty, mv, cx, cy;
            bit       xpos, ypos, wall, left, sd;
            if (r.req_type == REQ_WRITE) begin
                walls[r.cell_y * MAP_SIDE + r.cell_x] = r.cell_wall;
                return;
            end
            a32 = 32'(r.player_angle) + (32'(r.column) - 32'(center)) * 32'(spread);
            c = sine_q14(4 * longint'(a32[15:6]) + TRIG_ENTRIES);
            s = sine_q14(4 * longint'(a32[15:6]));
            ac = c < 0 ? -c : c;
            as = s < 0 ? -s : s;
            major = ac > as ? ac : as;
            if (major == 0) major = 1;
            dxm = (longint'(ac) * 65536) / major;
            dym = (longint'(as) * 65536) / major;
            xpos = c > 0;
            ypos = s > 0;
            cq = longint'(cell_size ? cell_size : 8'd1) << 8;
            px = r.pos_x;
            py = r.pos_y;
            wall = 0; left = 0; sd = 0;
            for (int st = 0; st < MAX_STEPS; st++) begin
                if (xpos) tx = cq - fmod(px, cq);
                else begin
                    if (fmod(px, cq) == 0) px--;
                    tx = -fmod(px, cq);
                end
                if (ypos) ty = cq - fmod(py, cq);
                else begin
                    if (fmod(py, cq) == 0) py--;
                    ty = -fmod(py, cq);
                end
                atx = tx < 0 ? -tx : tx;
                aty = ty < 0 ? -ty : ty;
                if (atx * dym < aty * dxm) begin
                    px += tx;
                    mv = dxm ? (atx * dym) / dxm : 0;
                    py += ypos ? mv : -mv;
                    if (!xpos) px--;
                    sd = 0;
                end else begin
                    py += ty;
                    mv = dym ? (aty * dxm) / dym : 0;
                    px += xpos ? mv : -mv;
                    if (!ypos) py--;
                    sd = 1;
                end
                cx = fdiv(px, cq);
                cy = fdiv(py, cq);
                if (cx >= 0 && cx < MAP_SIDE && cy >= 0 && cy < MAP_SIDE) begin
                    if (walls[cy * MAP_SIDE + cx]) begin
                        wall = 1;
                        break;
                    end
                end else left = 1;
            end
            e.column_out = r.column;
            e.hit_x      = clip(px);
            e.hit_y      = clip(py);
            e.side       = sd;
            e.ray_angle  = a32[15:0];
            e.wall_hit   = wall;
            e.left_map   = left;
            pending_hits.push_back(e);
        endfunction

        function void check_result(rsp_t a);
            rsp_t e;
            if (pending_hits.size() == 0) begin
                $error("result beat with no cast outstanding (column %0d)", a.column_out);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (a.column_out !== e.column_out) begin
                $error("column_out exp %0d got %0d", e.column_out, a.column_out); errors++;
            end
            if (a.hit_x !== e.hit_x) begin
                $error("hit_x exp %0d got %0d", e.hit_x, a.hit_x); errors++;
            end
            if (a.hit_y !== e.hit_y) begin
                $error("hit_y exp %0d got %0d", e.hit_y, a.hit_y); errors++;
            end
            if (a.side !== e.side) begin
                $error("side exp %0d got %0d", e.side, a.side); errors++;
            end
            if (a.ray_angle !== e.ray_angle) begin
                $error("ray_angle exp %0d got %0d", e.ray_angle, a.ray_angle); errors++;
            end
            if (a.wall_hit !== e.wall_hit) begin
                $error("wall_hit exp %0d got %0d", e.wall_hit, a.wall_hit); errors++;
            end
            if (a.left_map !== e.left_map) begin
                $error("left_map exp %0d got %0d", e.left_map, a.left_map); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    grce_req_if req_if ();
    grce_rsp_if rsp_if ();
    grce_cfg_if cfg_if ();

    grid_ray_cast_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    ray_scoreboard sb = new();

    // idle percentages for sender gaps and receiver stalls
    int send_idle_pct;
    int recv_stall_pct;

    localparam int ITEMS_PER_PHASE = 237;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 200;   // longer than the longest cast

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: ready changes on the falling edge only
    always @(negedge i_clk) begin
        rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        rsp_t got;
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.column_out = rsp_if.column_out;
            got.hit_x      = rsp_if.hit_x;
            got.hit_y      = rsp_if.hit_y;
            got.side       = rsp_if.side;
            got.ray_angle  = rsp_if.ray_angle;
            got.wall_hit   = rsp_if.wall_hit;
            got.left_map   = rsp_if.left_map;
            sb.check_result(got);
        end
    end

    // Drive one request beat; called at a falling edge, returns at one.
    task automatic send_req(req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        = 1'b1;
        req_if.req_type     = r.req_type;
        req_if.cell_x       = r.cell_x;
        req_if.cell_y       = r.cell_y;
        req_if.cell_wall    = r.cell_wall;
        req_if.pos_x        = r.pos_x;
        req_if.pos_y        = r.pos_y;
        req_if.player_angle = r.player_angle;
        req_if.column       = r.column;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(r);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Let every cast drain, then give a trailing map write time to settle.
    task automatic drain();
        while (sb.pending_hits.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic req_t map_write(int x, int y, bit w);
        req_t r;
        r = '{default: '0};
        r.req_type  = REQ_WRITE;
        r.cell_x    = x;
        r.cell_y    = y;
        r.cell_wall = w;
        return r;
    endfunction

    function automatic req_t cast(int px, int py, int ang, int col);
        req_t r;
        r = '{default: '0};
        r.req_type     = REQ_CAST;
        r.pos_x        = px;
        r.pos_y        = py;
        r.player_angle = ang;
        r.column       = col;
        return r;
    endfunction

    // One random position: mostly inside the map, sometimes snapped to a cell edge.
    function automatic int rand_pos();
        longint cq, span, p;
        cq   = longint'(sb.cell_size ? sb.cell_size : 8'd1) << 8;
        span = 16 * cq;
        if ($urandom_range(99) < 80 && span <= (1 << POS_IN_W))
            p = $urandom_range(int'(span) - 1, 0);
        else
            p = $urandom_range((1 << POS_IN_W) - 1, 0);
        if ($urandom_range(99) < 15) p = (p / cq) * cq;
        return int'(p);
    endfunction

    function automatic req_t rand_item();
        req_t r;
        if ($urandom_range(99) < 25) begin
            r = map_write($urandom_range(15), $urandom_range(15), $urandom_range(99) < 40);
            // noise in the unused cast fields
            r.pos_x = $urandom; r.pos_y = $urandom;
            r.player_angle = $urandom; r.column = $urandom;
        end else begin
            r = cast(rand_pos(), rand_pos(), $urandom_range(65535), $urandom_range(1023));
            r.cell_x = $urandom; r.cell_y = $urandom; r.cell_wall = $urandom;
        end
        return r;
    endfunction

    task automatic directed();
        // corner walls (one cleared again) plus one interior wall, then casts at field extremes and other edge cases
        send_req(map_write(0, 0, 1));
        send_req(map_write(15, 15, 1));
        send_req(map_write(15, 0, 1));
        send_req(map_write(0, 15, 1));
        send_req(map_write(8, 5, 1));
        send_req(map_write(15, 0, 0));
        send_req(cast(0, 0, 0, 0));
        send_req(cast(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1023));
        send_req(cast(512 * 256, 320 * 256, 0, 256));       // straight east
        send_req(cast(512 * 256, 320 * 256, 16384, 256));   // straight north
        send_req(cast(512 * 256, 320 * 256, 32768, 256));   // straight west
        send_req(cast(512 * 256, 320 * 256, 49152, 256));   // straight south
        send_req(cast(64 * 256, 64 * 256, 8192, 256));      // exact diagonal, start on edges
        send_req(cast(64 * 256, 64 * 256, 40960, 256));     // negative diagonal from a corner
        send_req(cast(100, 90, 24576, 511));
        send_req(cast(3 * 64 * 256, 7 * 64 * 256, 57344, 0));
        send_req(cast(200000, 10, 12000, 700));
        send_req(cast(5, 262143, 30000, 300));              // near top map border
        send_req(cast(300000, 300000, 33000, 256));         // outside the map
        send_req(cast(128 * 256, 128 * 256, 1, 256));       // y component rounds to zero
    endtask

    initial begin
        req_t  r;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_WRITE;
        req_if.cell_x = '0; req_if.cell_y = '0; req_if.cell_wall = 1'b0;
        req_if.pos_x = '0; req_if.pos_y = '0; req_if.player_angle = '0; req_if.column = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_CELL_SIZE;
        cfg_if.data  = '0;
        rsp_if.ready = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // idle modes rotate: none, sender gaps, receiver stalls, both
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin   // upper extremes
                        write_reg(CFG_CELL_SIZE, 10'd255);
                        write_reg(CFG_RAY_SPREAD, 10'd255);
                        write_reg(CFG_CENTER_COLUMN, 10'd1023);
                    end
                    2: begin   // lower extremes
                        write_reg(CFG_CELL_SIZE, 10'd1);
                        write_reg(CFG_RAY_SPREAD, 10'd0);
                        write_reg(CFG_CENTER_COLUMN, 10'd0);
                    end
                    3: begin   // zero cell size acts as one
                        write_reg(CFG_CELL_SIZE, 10'd0);
                        write_reg(CFG_RAY_SPREAD, 10'($urandom_range(255)));
                        write_reg(CFG_CENTER_COLUMN, 10'($urandom_range(1023)));
                    end
                    default: begin
                        write_reg(CFG_CELL_SIZE, 10'($urandom_range(255, 1)));
                        write_reg(CFG_RAY_SPREAD, 10'($urandom_range(255)));
                        write_reg(CFG_CENTER_COLUMN, 10'($urandom_range(1023)));
                    end
                endcase
            end
            if (ph == 0) directed();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = rand_item();
                send_req(r);
            end
        end

        drain();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
src/grce_pkg.sv
src/grce_if.sv
src/grce_ram.sv
src/grce_div.sv
src/grid_ray_cast_engine.sv
sim/tb_top.sv
